[rtl/core/bpme_pkg.sv]
`default_nettype none
package bpme_pkg;
  localparam int MaxText = 64;
  localparam int MaxMerges = 512;
  localparam int TokW = 10;
  localparam int IdxW = 9;
  localparam int CntW = 7;
  localparam int PosW = 6;
  localparam int MiuW = 10;
  localparam logic [TokW-1:0] ByteTokens = 10'd256;
  localparam logic KindRule = 1'b0;
  localparam logic KindText = 1'b1;

  typedef logic [TokW-1:0] tok_t;

  // rule broadcast to every cell during the sweep state
  typedef struct packed {
    logic en;
    tok_t left;
    tok_t right;
    tok_t merged;
  } rule_t;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_SWEEP = 5'b00100,
    ST_PACK  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;
endpackage
`default_nettype wire

[rtl/core/bpme_cell.sv]
`default_nettype none
// One buffer slot. A sweep marks a merge left to right through a carry chain
// (one link per cell); pack shifts valid tokens toward slot 0; emit shifts out.
module bpme_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bpme_pkg::rule_t   rule,
  input  wire logic              load_en,
  input  wire bpme_pkg::tok_t    load_tok,
  input  wire logic              shift_en,
  input  wire logic              clear,
  input  wire bpme_pkg::tok_t    nb_tok,
  input  wire logic              nb_vld,
  input  wire logic              carry_in,
  output logic                   carry_out,
  output bpme_pkg::tok_t         tok,
  output logic                   vld
);
  bpme_pkg::tok_t tok_r, tok_nxt;
  logic vld_r, vld_nxt;
  logic hit, absorb;

  // absorb when the left neighbor merged into itself
  assign absorb = carry_in;
  assign hit = !carry_in && vld_r && nb_vld && tok_r == rule.left && nb_tok == rule.right;
  assign carry_out = hit;

  always_comb begin
    tok_nxt = tok_r;
    vld_nxt = vld_r;
    priority if (clear) begin
      vld_nxt = 1'b0;
    end else if (load_en) begin
      tok_nxt = load_tok;
      vld_nxt = 1'b1;
    end else if (rule.en) begin
      if (absorb) vld_nxt = 1'b0;
      else if (hit) tok_nxt = rule.merged;
    end else if (shift_en) begin
      tok_nxt = nb_tok;
      vld_nxt = nb_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
    tok_r <= tok_nxt;
  end

  assign tok = tok_r;
  assign vld = vld_r;
endmodule
`default_nettype wire

[rtl/core/bpme_chain.sv]
`default_nettype none
module bpme_chain (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire bpme_pkg::rule_t                      rule,
  input  wire logic [bpme_pkg::MaxText-1:0]         load_en,
  input  wire bpme_pkg::tok_t                       load_tok,
  input  wire logic [bpme_pkg::MaxText-1:0]         shift_en,
  input  wire logic                                 clear,
  output bpme_pkg::tok_t                            head_tok,
  output logic [bpme_pkg::MaxText-1:0]              vld
);
  bpme_pkg::tok_t tk [bpme_pkg::MaxText];
  logic [bpme_pkg::MaxText:0] cy;
  assign cy[0] = 1'b0;

  for (genvar i = 0; i < bpme_pkg::MaxText; i++) begin : g_cell
    bpme_pkg::tok_t nt;
    logic nv;
    if (i == bpme_pkg::MaxText - 1) begin : g_end
      assign nt = '0;
      assign nv = 1'b0;
    end else begin : g_mid
      assign nt = tk[i+1];
      assign nv = vld[i+1];
    end
    bpme_cell u_cell (
      .clk(clk), .rst_n(rst_n), .rule(rule), .load_en(load_en[i]),
      .load_tok(load_tok), .shift_en(shift_en[i]), .clear(clear),
      .nb_tok(nt), .nb_vld(nv), .carry_in(cy[i]), .carry_out(cy[i+1]),
      .tok(tk[i]), .vld(vld[i])
    );
  end

  assign head_tok = tk[0];
endmodule
`default_nettype wire

[rtl/core/byte_pair_merge_encoder.sv]
`default_nettype none
// Sequence: after the last byte each rule costs a table read, a sweep of the
// cell row and a compaction that shifts tokens toward slot 0 until no gap is
// left; with no rules the row is only compacted. Then one token leaves per cycle
// while out_ready is high, and loading resumes the cycle after the last.
// Throughput: rule and text items one per cycle while loading; the input stalls
// from the last byte until the last token has left.
// Reset: synchronous active low; clears the count, flag, register and row.
module byte_pair_merge_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [8:0]  in_merge_index,
  input  wire logic [9:0]  in_pair_left,
  input  wire logic [9:0]  in_pair_right,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       out_token,
  output logic             out_last_token,
  output logic             out_truncated,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [9:0]  cfg_data
);
  localparam int MT = bpme_pkg::MaxText;

  bpme_pkg::state_t st_r, st_nxt;
  logic [bpme_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic ovf_r, ovf_nxt;
  logic [bpme_pkg::MiuW-1:0] miu_r;
  logic [bpme_pkg::MiuW-1:0] m_r, m_nxt, lim;
  bpme_pkg::tok_t ltab [bpme_pkg::MaxMerges];
  bpme_pkg::tok_t rtab [bpme_pkg::MaxMerges];
  bpme_pkg::tok_t lrd_r, rrd_r;
  bpme_pkg::rule_t rule;
  logic [MT-1:0] load_en, shift_en, vld;
  logic clear;
  bpme_pkg::tok_t head;
  logic in_xfer, out_xfer, gap;
  logic [MT-1:0] pre;

  assign in_ready = st_r == bpme_pkg::ST_LOAD;
  assign cfg_ready = 1'b1;
  assign in_xfer = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign lim = (miu_r > 10'(bpme_pkg::MaxMerges)) ? 10'(bpme_pkg::MaxMerges) : miu_r;

  // hold the register
  always_ff @(posedge clk) begin
    if (!rst_n) miu_r <= '0;
    else if (cfg_valid) miu_r <= cfg_data;
  end

  // write and read the rule tables
  always_ff @(posedge clk) begin
    if (in_xfer && in_kind == bpme_pkg::KindRule) begin
      ltab[in_merge_index] <= in_pair_left;
      rtab[in_merge_index] <= in_pair_right;
    end
    lrd_r <= ltab[m_r[bpme_pkg::IdxW-1:0]];
    rrd_r <= rtab[m_r[bpme_pkg::IdxW-1:0]];
  end

  assign rule.en = st_r == bpme_pkg::ST_SWEEP;
  assign rule.left = lrd_r;
  assign rule.right = rrd_r;
  assign rule.merged = bpme_pkg::ByteTokens + m_r;

  // pack: each slot takes its neighbor from the first hole onward
  always_comb begin
    pre[0] = !vld[0];
    for (int i = 1; i < MT; i++) pre[i] = pre[i-1] || !vld[i];
  end
  always_comb begin
    gap = 1'b0;
    for (int i = 0; i < MT - 1; i++) if (pre[i] && vld[i+1]) gap = 1'b1;
  end
  always_comb begin
    shift_en = '0;
    if (st_r == bpme_pkg::ST_PACK) shift_en = pre;
    else if (st_r == bpme_pkg::ST_EMIT && out_xfer) shift_en = '1;
  end

  always_comb begin
    load_en = '0;
    if (in_xfer && in_kind == bpme_pkg::KindText && cnt_r < 7'(MT))
      load_en[cnt_r[bpme_pkg::PosW-1:0]] = 1'b1;
  end
  assign clear = 1'b0;

  bpme_chain u_chain (
    .clk(clk), .rst_n(rst_n), .rule(rule), .load_en(load_en),
    .load_tok({2'b00, in_text_byte}), .shift_en(shift_en), .clear(clear),
    .head_tok(head), .vld(vld)
  );

  // sequence load, then per rule fetch, sweep and pack (pack alone with no rules), then emit
  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    m_nxt = m_r;
    unique case (st_r)
      bpme_pkg::ST_LOAD: begin
        if (in_xfer && in_kind == bpme_pkg::KindText) begin
          if (cnt_r < 7'(MT)) cnt_nxt = cnt_r + 7'd1;
          else ovf_nxt = 1'b1;
          if (in_last_byte) begin
            m_nxt = '0;
            st_nxt = (lim == '0) ? bpme_pkg::ST_PACK : bpme_pkg::ST_FETCH;
          end
        end
      end
      bpme_pkg::ST_FETCH: st_nxt = bpme_pkg::ST_SWEEP;
      bpme_pkg::ST_SWEEP: begin
        m_nxt = m_r + 10'd1;
        st_nxt = bpme_pkg::ST_PACK;
      end
      bpme_pkg::ST_PACK: begin
        if (!gap) st_nxt = (m_r == lim) ? bpme_pkg::ST_EMIT : bpme_pkg::ST_FETCH;
      end
      bpme_pkg::ST_EMIT: begin
        if (out_xfer && !vld[1]) begin
          st_nxt = bpme_pkg::ST_LOAD;
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      default: st_nxt = bpme_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bpme_pkg::ST_LOAD;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      m_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      m_r <= m_nxt;
    end
  end

  assign out_valid = st_r == bpme_pkg::ST_EMIT && vld[0];
  assign out_token = head;
  assign out_last_token = !vld[1];
  assign out_truncated = ovf_r;
endmodule
`default_nettype wire

[rtl/core/bpme_checker.sv]
`default_nettype none
module bpme_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [9:0] out_token,
  input wire logic out_last_token
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token))
    else $error("result dropped while stalled");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken during emit");
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_token |=> !out_valid)
    else $error("token after last");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output after reset");
endmodule
bind byte_pair_merge_encoder bpme_checker u_bpme_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_token(out_token),
  .out_last_token(out_last_token)
);
`default_nettype wire
